// File: rtl/core/led_serpentine_frame_reorder_assert.svh
// Assertion macros for the serpentine frame reorder block.
`ifndef LED_SERPENTINE_FRAME_REORDER_ASSERT_SVH
`define LED_SERPENTINE_FRAME_REORDER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LSFR_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LSFR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/lsfr_pkg.sv
// Shared types, constants and helpers for the serpentine frame reorder block.
package lsfr_pkg;

  localparam int unsigned MAX_COLUMNS = 64;
  localparam int unsigned MAX_ROWS    = 32;
  localparam int unsigned MAX_STRINGS = 8;

  localparam int unsigned COL_W   = $clog2(MAX_COLUMNS);
  localparam int unsigned ROW_W   = $clog2(MAX_ROWS);
  localparam int unsigned STR_W   = $clog2(MAX_STRINGS);
  localparam int unsigned ADDR_W  = COL_W + ROW_W;
  localparam int unsigned DEPTH   = MAX_COLUMNS * MAX_ROWS;
  localparam int unsigned PIXEL_W = 24;

  localparam int unsigned CFG_COLS_W = 7;
  localparam int unsigned CFG_ROWS_W = 6;
  localparam int unsigned CFG_STRS_W = 4;
  localparam int unsigned CFG_RPS_W  = 6;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLUMNS  = 2'd0,
    CFG_ROWS     = 2'd1,
    CFG_STRINGS  = 2'd2,
    CFG_ROWS_STR = 2'd3
  } lsfr_cfg_e;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_PAD   = 2'd2
  } lsfr_op_e;

  typedef struct packed {
    lsfr_op_e            op;
    logic [ADDR_W-1:0]   addr;
    logic [PIXEL_W-1:0]  pixel;
    logic                frame_end;
  } lsfr_entry_t;

  function automatic logic [CFG_COLS_W-1:0] sat_cols(input logic [CFG_COLS_W-1:0] v);
    if (v == '0) return CFG_COLS_W'(1);
    if (v > CFG_COLS_W'(MAX_COLUMNS)) return CFG_COLS_W'(MAX_COLUMNS);
    return v;
  endfunction

  function automatic logic [CFG_ROWS_W-1:0] sat_rows(input logic [CFG_ROWS_W-1:0] v);
    if (v == '0) return CFG_ROWS_W'(1);
    if (v > CFG_ROWS_W'(MAX_ROWS)) return CFG_ROWS_W'(MAX_ROWS);
    return v;
  endfunction

  function automatic logic [CFG_STRS_W-1:0] sat_strs(input logic [CFG_STRS_W-1:0] v);
    if (v == '0) return CFG_STRS_W'(1);
    if (v > CFG_STRS_W'(MAX_STRINGS)) return CFG_STRS_W'(MAX_STRINGS);
    return v;
  endfunction

endpackage

// File: rtl/core/lsfr_front.sv
// Front end: configuration registers, item classification and the serpentine walk.
module lsfr_front import lsfr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  kind_i,
  input  logic [COL_W-1:0]      column_i,
  input  logic [ROW_W-1:0]      row_i,
  input  logic [7:0]            red_in_i,
  input  logic [7:0]            green_in_i,
  input  logic [7:0]            blue_in_i,
  input  logic                  clear_busy_i,
  output logic                  push_valid_o,
  input  logic                  push_ready_i,
  output lsfr_entry_t           push_entry_o
);

  logic [CFG_COLS_W-1:0] cols_cfg_q;
  logic [CFG_ROWS_W-1:0] rows_cfg_q;
  logic [CFG_STRS_W-1:0] strs_cfg_q;
  logic [CFG_RPS_W-1:0]  rps_cfg_q;

  logic [STR_W-1:0] str_q, str_d;
  logic [ROW_W-1:0] ris_q, ris_d;
  logic [COL_W-1:0] cstep_q, cstep_d;

  logic [CFG_COLS_W-1:0] cols;
  logic [CFG_ROWS_W-1:0] rows;
  logic [CFG_STRS_W-1:0] strs;
  logic [CFG_RPS_W-1:0]  rps;

  logic [STR_W-1:0] str_e;
  logic [ROW_W-1:0] ris_e;
  logic [COL_W-1:0] cstep_e;
  logic [8:0]       y;
  logic [COL_W-1:0] x;
  logic             pad, last_col, last_row, last_str, wr_ok, accept;

  assign cols = sat_cols(cols_cfg_q);
  assign rows = sat_rows(rows_cfg_q);
  assign strs = sat_strs(strs_cfg_q);
  assign rps  = sat_rows(rps_cfg_q);

  assign in_ready_o = push_ready_i && !clear_busy_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    str_e   = ({1'b0, str_q} >= strs) ? STR_W'(strs - 1'b1) : str_q;
    ris_e   = ({1'b0, ris_q} >= rps) ? ROW_W'(rps - 1'b1) : ris_q;
    cstep_e = ({1'b0, cstep_q} >= cols) ? COL_W'(cols - 1'b1) : cstep_q;

    y   = 9'(str_e) + 9'(ris_e) * 9'(strs);
    x   = ris_e[0] ? COL_W'(cols - 7'd1 - {1'b0, cstep_e}) : cstep_e;
    pad = y >= 9'(rows);

    last_col = ({1'b0, cstep_e} + 7'd1) >= cols;
    last_row = ({1'b0, ris_e} + 6'd1) >= rps;
    last_str = ({1'b0, str_e} + 4'd1) >= strs;

    wr_ok = ({1'b0, column_i} < cols) && ({1'b0, row_i} < rows);

    push_entry_o.pixel     = {red_in_i, green_in_i, blue_in_i};
    push_entry_o.frame_end = last_col && last_row && last_str;
    if (kind_i == 1'b0) begin
      push_entry_o.op   = OP_WRITE;
      push_entry_o.addr = {row_i, column_i};
    end else begin
      push_entry_o.op   = pad ? OP_PAD : OP_READ;
      push_entry_o.addr = {y[ROW_W-1:0], x};
    end
    push_valid_o = in_valid_i && !clear_busy_i && (kind_i || wr_ok);

    str_d   = str_e;
    ris_d   = ris_e;
    cstep_d = cstep_e + 1'b1;
    if (last_col) begin
      cstep_d = '0;
      ris_d   = ris_e + 1'b1;
      if (last_row) begin
        ris_d = '0;
        str_d = last_str ? '0 : STR_W'(str_e + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_cfg_q <= CFG_COLS_W'(59);
      rows_cfg_q <= CFG_ROWS_W'(26);
      strs_cfg_q <= CFG_STRS_W'(6);
      rps_cfg_q  <= CFG_RPS_W'(5);
      str_q      <= '0;
      ris_q      <= '0;
      cstep_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (lsfr_cfg_e'(cfg_idx_i))
          CFG_COLUMNS:  cols_cfg_q <= cfg_data_i[CFG_COLS_W-1:0];
          CFG_ROWS:     rows_cfg_q <= cfg_data_i[CFG_ROWS_W-1:0];
          CFG_STRINGS:  strs_cfg_q <= cfg_data_i[CFG_STRS_W-1:0];
          CFG_ROWS_STR: rps_cfg_q  <= cfg_data_i[CFG_RPS_W-1:0];
          default: ;
        endcase
      end
      if (accept && kind_i) begin
        str_q   <= str_d;
        ris_q   <= ris_d;
        cstep_q <= cstep_d;
      end
    end
  end

endmodule

// File: rtl/core/lsfr_queue.sv
// Short queue of classified operations between front and back.
module lsfr_queue import lsfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_valid_i,
  output logic        push_ready_o,
  input  lsfr_entry_t push_entry_i,
  output logic        pop_valid_o,
  input  logic        pop_i,
  output lsfr_entry_t pop_entry_o
);

  lsfr_entry_t       slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              push, pop;

  assign push_ready_o = cnt_q != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_entry_o  = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// File: rtl/core/lsfr_back.sv
// Back end: frame store, clearing pass, pixel read and output register.
module lsfr_back import lsfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        pop_valid_i,
  output logic        pop_o,
  input  lsfr_entry_t pop_entry_i,
  output logic        clear_busy_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic        padding_o,
  output logic        frame_end_o
);

  logic [PIXEL_W-1:0] mem [DEPTH];
  logic [PIXEL_W-1:0] rdata_q;
  logic [ADDR_W-1:0]  clr_cnt_q;
  logic               clearing_q;
  logic               res_valid_q, res_pad_q, res_end_q;

  logic               slot_free, is_result, rd_en, mem_we;
  logic [ADDR_W-1:0]  mem_wa;
  logic [PIXEL_W-1:0] mem_wd;

  assign slot_free = !res_valid_q || out_ready_i;

  always_comb begin
    is_result = 1'b0;
    case (pop_entry_i.op)
      OP_WRITE: is_result = 1'b0;
      OP_READ:  is_result = 1'b1;
      OP_PAD:   is_result = 1'b1;
      default:  is_result = 1'b0;
    endcase
    pop_o  = !clearing_q && pop_valid_i && (!is_result || slot_free);
    rd_en  = pop_o && (pop_entry_i.op == OP_READ);
    mem_we = clearing_q || (pop_o && (pop_entry_i.op == OP_WRITE));
    mem_wa = clearing_q ? clr_cnt_q : pop_entry_i.addr;
    mem_wd = clearing_q ? '0 : pop_entry_i.pixel;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rdata_q <= mem[pop_entry_i.addr];
    end
    if (pop_o && is_result) begin
      res_pad_q <= pop_entry_i.op == OP_PAD;
      res_end_q <= pop_entry_i.frame_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      clearing_q  <= 1'b1;
      res_valid_q <= 1'b0;
    end else begin
      if (clearing_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == ADDR_W'(DEPTH - 1)) begin
          clearing_q <= 1'b0;
        end
      end
      if (pop_o && is_result) begin
        res_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign clear_busy_o = clearing_q;
  assign out_valid_o  = res_valid_q;
  assign red_o        = res_pad_q ? 8'h00 : rdata_q[23:16];
  assign green_o      = res_pad_q ? 8'h00 : rdata_q[15:8];
  assign blue_o       = res_pad_q ? 8'h00 : rdata_q[7:0];
  assign padding_o    = res_pad_q;
  assign frame_end_o  = res_end_q;

endmodule

// File: rtl/core/led_serpentine_frame_reorder.sv
// Top level of the serpentine LED frame reorder block.
// Takes one word per clock when not stalled: a write stores an in-range pixel, a fetch
// returns the next pixel in string order through a queue slot and then the read data
// and valid registers. The pace is set by the single write port and single read port
// of the 2048-entry frame store, one access per clock. After reset a clearing pass
// zeroes every entry with no word accepted; configuration writes are taken throughout.
`include "led_serpentine_frame_reorder_assert.svh"
module led_serpentine_frame_reorder import lsfr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  kind_i,
  input  logic [COL_W-1:0]      column_i,
  input  logic [ROW_W-1:0]      row_i,
  input  logic [7:0]            red_in_i,
  input  logic [7:0]            green_in_i,
  input  logic [7:0]            blue_in_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            red_o,
  output logic [7:0]            green_o,
  output logic [7:0]            blue_o,
  output logic                  padding_o,
  output logic                  frame_end_o
);

  logic        push_valid, push_ready, pop_valid, pop, clear_busy;
  lsfr_entry_t push_entry, pop_entry;

  lsfr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .column_i     (column_i),
    .row_i        (row_i),
    .red_in_i     (red_in_i),
    .green_in_i   (green_in_i),
    .blue_in_i    (blue_in_i),
    .clear_busy_i (clear_busy),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  lsfr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_entry_o  (pop_entry)
  );

  lsfr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_o        (pop),
    .pop_entry_i  (pop_entry),
    .clear_busy_o (clear_busy),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .padding_o    (padding_o),
    .frame_end_o  (frame_end_o)
  );

  `LSFR_ASSERT_IMPL(a_clear_blocks_input, clear_busy, !in_ready_o, "word accepted while clearing")
  `LSFR_ASSERT_IMPL(a_no_pop_empty, pop, pop_valid && !clear_busy, "queue popped while empty")
  `LSFR_ASSERT_IMPL(a_no_push_full, push_valid && in_ready_o, push_ready, "queue pushed while full")
  `LSFR_ASSERT_NEXT(a_clear_finishes, clear_busy && !$past(clear_busy), clear_busy, "clear ended early")

endmodule

// File: sim/tb_top.sv
// Testbench for the serpentine LED frame reorder: directed table, then checked random words.
module tb_top import lsfr_pkg::*; ();

  localparam bit KIND_WRITE = 1'b0;
  localparam bit KIND_FETCH = 1'b1;
  localparam int LIMIT = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int N_DIRECTED = 17;

  typedef struct packed {
    logic       kind;
    logic [5:0] column;
    logic [4:0] row;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_cmd_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       padding;
    logic       frame_end;
  } led_pixel_t;

  typedef struct packed {
    pixel_cmd_t cmd;
    logic       fixed;
    led_pixel_t want;
  } directed_row_t;

  localparam led_pixel_t NO_PIXEL = '0;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic                  kind_i;
  logic [COL_W-1:0]      column_i;
  logic [ROW_W-1:0]      row_i;
  logic [7:0]            red_in_i;
  logic [7:0]            green_in_i;
  logic [7:0]            blue_in_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [7:0]            red_o;
  logic [7:0]            green_o;
  logic [7:0]            blue_o;
  logic                  padding_o;
  logic                  frame_end_o;

  led_serpentine_frame_reorder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .column_i    (column_i),
    .row_i       (row_i),
    .red_in_i    (red_in_i),
    .green_in_i  (green_in_i),
    .blue_in_i   (blue_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .padding_o   (padding_o),
    .frame_end_o (frame_end_o)
  );

  // local copy of the frame store, walk position and registers
  logic [23:0] frame_copy [MAX_COLUMNS*MAX_ROWS];
  logic [2:0]  walk_string;
  logic [4:0]  walk_row;
  logic [5:0]  walk_col;
  logic [6:0]  reg_cols;
  logic [5:0]  reg_rows;
  logic [3:0]  reg_strs;
  logic [5:0]  reg_rps;

  led_pixel_t    pending_pixels [$];
  directed_row_t directed_rows [N_DIRECTED];
  int            mismatches;
  int            cycles;
  int            hold_request;
  bit            idle_on;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int unsigned clamp_limit(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int pick_gap();
    int x;
    if (!idle_on) return 0;
    x = $urandom_range(0, 99);
    if (x < 60) return 0;
    if (x < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // advance the walk or update the store; returns 1 when a pixel goes out
  function automatic bit step_frame(input pixel_cmd_t w, output led_pixel_t res);
    int unsigned cols, rows, strs, rps, y, x;
    logic [23:0] px;
    bit last_col, last_row, last_str;
    cols = clamp_limit(reg_cols, MAX_COLUMNS);
    rows = clamp_limit(reg_rows, MAX_ROWS);
    strs = clamp_limit(reg_strs, MAX_STRINGS);
    rps  = clamp_limit(reg_rps, MAX_ROWS);
    res = NO_PIXEL;
    if (w.kind == KIND_WRITE) begin
      if (w.column < cols && w.row < rows)
        frame_copy[w.row * MAX_COLUMNS + w.column] = {w.red, w.green, w.blue};
      return 1'b0;
    end
    if (walk_string >= strs) walk_string = 3'(strs - 1);
    if (walk_row >= rps) walk_row = 5'(rps - 1);
    if (walk_col >= cols) walk_col = 6'(cols - 1);
    y = walk_string + walk_row * strs;
    x = walk_row[0] ? (cols - 1 - walk_col) : walk_col;
    px = '0;
    if (y < rows) px = frame_copy[y * MAX_COLUMNS + x];
    last_col = (int'(walk_col) + 1 >= cols);
    last_row = (int'(walk_row) + 1 >= rps);
    last_str = (int'(walk_string) + 1 >= strs);
    res.red       = px[23:16];
    res.green     = px[15:8];
    res.blue      = px[7:0];
    res.padding   = (y >= rows);
    res.frame_end = last_col && last_row && last_str;
    if (!last_col) begin
      walk_col = walk_col + 1'b1;
    end else begin
      walk_col = '0;
      if (!last_row) begin
        walk_row = walk_row + 1'b1;
      end else begin
        walk_row = '0;
        walk_string = last_str ? 3'd0 : walk_string + 1'b1;
      end
    end
    return 1'b1;
  endfunction

  function automatic pixel_cmd_t random_word();
    pixel_cmd_t w;
    w = pixel_cmd_t'({$urandom, $urandom});
    if ($urandom_range(0, 1) == 1) begin
      w.kind = KIND_FETCH;
    end else begin
      w.kind = KIND_WRITE;
      if ($urandom_range(0, 99) < 85) begin
        w.column = 6'($urandom_range(0, clamp_limit(reg_cols, MAX_COLUMNS) - 1));
        w.row    = 5'($urandom_range(0, clamp_limit(reg_rows, MAX_ROWS) - 1));
      end
    end
    return w;
  endfunction

  // called at a falling edge; returns at a falling edge after acceptance
  task automatic send_word(input pixel_cmd_t w, input bit fixed, input led_pixel_t want,
                           input int gap);
    led_pixel_t res;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= w.kind;
    column_i   <= w.column;
    row_i      <= w.row;
    red_in_i   <= w.red;
    green_in_i <= w.green;
    blue_in_i  <= w.blue;
    do @(posedge clk_i); while (!in_ready_o);
    if (step_frame(w, res)) pending_pixels.push_back(fixed ? want : res);
    @(negedge clk_i);
  endtask

  task automatic cfg_write(input lsfr_cfg_e idx, input logic [6:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_COLUMNS:  reg_cols = data;
      CFG_ROWS:     reg_rows = data[5:0];
      CFG_STRINGS:  reg_strs = data[3:0];
      CFG_ROWS_STR: reg_rps  = data[5:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic apply_settings(input logic [6:0] c, input logic [6:0] r,
                                input logic [6:0] s, input logic [6:0] p);
    cfg_write(CFG_COLUMNS, c);
    cfg_write(CFG_ROWS, r);
    cfg_write(CFG_STRINGS, s);
    cfg_write(CFG_ROWS_STR, p);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // drop valid, drain results, let trailing writes land
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // receiver: random stalls plus requested long hold-offs
  initial begin
    int stall_left;
    int g;
    stall_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request > 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        g = pick_gap();
        out_ready_i <= (g == 0);
        if (g > 0) stall_left = g - 1;
      end
    end
  end

  always @(posedge clk_i) begin
    led_pixel_t got;
    led_pixel_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{red_o, green_o, blue_o, padding_o, frame_end_o};
      if (pending_pixels.size() == 0) begin
        if (mismatches < 10) $display("unexpected pixel %h at cycle %0d", got, cycles);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
            got.padding !== want.padding || got.frame_end !== want.frame_end) begin
          if (mismatches < 10)
            $display("pixel mismatch at cycle %0d: rgb %h%h%h pad %b end %b, want %h%h%h %b %b",
                     cycles, got.red, got.green, got.blue, got.padding, got.frame_end,
                     want.red, want.green, want.blue, want.padding, want.frame_end);
          mismatches++;
        end
      end
    end
  end

  initial begin
    logic [6:0] c, r, s, p;
    mismatches = 0;
    cycles = 0;
    hold_request = 0;
    idle_on = 1'b1;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_COLUMNS;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    kind_i = KIND_WRITE;
    column_i = '0;
    row_i = '0;
    red_in_i = '0;
    green_in_i = '0;
    blue_in_i = '0;
    foreach (frame_copy[i]) frame_copy[i] = '0;
    walk_string = '0;
    walk_row = '0;
    walk_col = '0;
    reg_cols = 7'd59;
    reg_rows = 6'd26;
    reg_strs = 4'd6;
    reg_rps  = 6'd5;

    // panel 2 x 3, two strings of two rows: string 1 ends on a padding row
    directed_rows = '{
      '{'{KIND_FETCH, 6'd0,  5'd0,  8'h00, 8'h00, 8'h00}, 1'b1, '{8'h00, 8'h00, 8'h00, 1'b0, 1'b0}},
      '{'{KIND_WRITE, 6'd0,  5'd0,  8'hff, 8'hff, 8'hff}, 1'b0, NO_PIXEL},
      '{'{KIND_WRITE, 6'd1,  5'd0,  8'h00, 8'h00, 8'h00}, 1'b0, NO_PIXEL},
      '{'{KIND_WRITE, 6'd0,  5'd1,  8'h12, 8'h34, 8'h56}, 1'b0, NO_PIXEL},
      '{'{KIND_WRITE, 6'd1,  5'd2,  8'ha5, 8'h5a, 8'hc3}, 1'b0, NO_PIXEL},
      '{'{KIND_WRITE, 6'd63, 5'd31, 8'hff, 8'hff, 8'hff}, 1'b0, NO_PIXEL},
      '{'{KIND_WRITE, 6'd2,  5'd0,  8'h11, 8'h22, 8'h33}, 1'b0, NO_PIXEL},
      '{'{KIND_WRITE, 6'd0,  5'd3,  8'h44, 8'h55, 8'h66}, 1'b0, NO_PIXEL},
      '{'{KIND_FETCH, 6'd0,  5'd0,  8'h00, 8'h00, 8'h00}, 1'b0, NO_PIXEL},
      '{'{KIND_FETCH, 6'd0,  5'd0,  8'h00, 8'h00, 8'h00}, 1'b0, NO_PIXEL},
      '{'{KIND_FETCH, 6'd0,  5'd0,  8'h00, 8'h00, 8'h00}, 1'b0, NO_PIXEL},
      '{'{KIND_FETCH, 6'd0,  5'd0,  8'h00, 8'h00, 8'h00}, 1'b0, NO_PIXEL},
      '{'{KIND_FETCH, 6'd0,  5'd0,  8'h00, 8'h00, 8'h00}, 1'b0, NO_PIXEL},
      '{'{KIND_FETCH, 6'd0,  5'd0,  8'h00, 8'h00, 8'h00}, 1'b1, '{8'h00, 8'h00, 8'h00, 1'b1, 1'b0}},
      '{'{KIND_FETCH, 6'd0,  5'd0,  8'h00, 8'h00, 8'h00}, 1'b1, '{8'h00, 8'h00, 8'h00, 1'b1, 1'b1}},
      '{'{KIND_FETCH, 6'd0,  5'd0,  8'h00, 8'h00, 8'h00}, 1'b0, NO_PIXEL},
      '{'{KIND_FETCH, 6'd63, 5'd31, 8'hff, 8'hff, 8'hff}, 1'b0, NO_PIXEL}
    };

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    apply_settings(7'd2, 7'd3, 7'd2, 7'd2);
    foreach (directed_rows[i])
      send_word(directed_rows[i].cmd, directed_rows[i].fixed, directed_rows[i].want, pick_gap());

    for (int phase = 0; phase < 10; phase++) begin
      settle();
      case (phase)
        0: begin c = 7'd1;   r = 7'd1;   s = 7'd1;   p = 7'd1;   end
        1: begin c = 7'd64;  r = 7'd32;  s = 7'd8;   p = 7'd32;  end
        2: begin c = 7'd0;   r = 7'd0;   s = 7'd0;   p = 7'd0;   end
        3: begin c = 7'h7f;  r = 7'h7f;  s = 7'h7f;  p = 7'h7f;  end
        default: begin
          c = 7'($urandom_range(1, 8));
          r = 7'($urandom_range(1, 6));
          s = 7'($urandom_range(1, 4));
          p = 7'($urandom_range(1, 4));
        end
      endcase
      apply_settings(c, r, s, p);
      idle_on = (phase != 7);
      if (phase == 5) hold_request = 300;
      repeat (40) send_word(random_word(), 1'b0, NO_PIXEL, pick_gap());
    end

    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
